// ===== src/mpd_pkg.sv =====
// shared widths, codes and types of the min point distance block
package mpd_pkg;

  // coordinate format
  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 12;
  localparam int DIST_BITS  = COORD_BITS + 1;
  localparam int MAG_BITS   = COORD_BITS;
  localparam int SQ_BITS    = 2 * DIST_BITS;

  // start distance after reset
  localparam int START_METERS = 100;
  localparam logic [DIST_BITS-1:0] START_RESET = DIST_BITS'(START_METERS << FRAC_BITS);
  localparam logic [SQ_BITS-1:0] START_SQ_RESET =
    SQ_BITS'(START_RESET) * SQ_BITS'(START_RESET);

  // point queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // root unit iteration counter
  localparam int ROOT_CNT_BITS = $clog2(DIST_BITS);

  // configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_REF_X      = 2'd0,
    CFG_REF_Y      = 2'd1,
    CFG_REF_Z      = 2'd2,
    CFG_START_DIST = 2'd3
  } cfg_reg_e_t;

  // one queued point: per-axis distance magnitudes and cloud end mark
  typedef struct packed {
    logic [MAG_BITS-1:0] mag_x;
    logic [MAG_BITS-1:0] mag_y;
    logic [MAG_BITS-1:0] mag_z;
    logic                last;
  } entry_t;

  // axis being squared in the back end
  typedef enum logic [1:0] {
    AX_X = 2'd0,
    AX_Y = 2'd1,
    AX_Z = 2'd2
  } axis_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_ADD,
    BK_CMP,
    BK_SEED_MUL,
    BK_SEED_WR,
    BK_ROOT_START,
    BK_ROOT_WAIT
  } back_state_t;

  // root unit request and response
  typedef struct packed {
    logic               start;
    logic [SQ_BITS-1:0] operand;
  } root_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIST_BITS-1:0] root;
  } root_rsp_t;

endpackage

// ===== src/mpd_front.sv =====
// front end: takes point beats and forms per-axis distance magnitudes
module mpd_front import mpd_pkg::*; (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  input  logic [COORD_BITS-1:0] point_z,
  input  logic                  last_point,
  input  logic [COORD_BITS-1:0] ref_x,
  input  logic [COORD_BITS-1:0] ref_y,
  input  logic [COORD_BITS-1:0] ref_z,
  input  logic                  q_full,
  output logic                  q_push,
  output entry_t                q_entry
);

  // |p - r| of two signed coordinates, always below 2^COORD_BITS
  function automatic logic [MAG_BITS-1:0] axis_mag(
    input logic [COORD_BITS-1:0] p,
    input logic [COORD_BITS-1:0] r
  );
    logic [DIST_BITS-1:0] diff;
    logic [DIST_BITS-1:0] neg;
    diff = {p[COORD_BITS-1], p} - {r[COORD_BITS-1], r};
    neg  = ~diff + DIST_BITS'(1);
    return diff[DIST_BITS-1] ? neg[MAG_BITS-1:0] : diff[MAG_BITS-1:0];
  endfunction

  // accept while the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // classify the beat into an entry
  always_comb begin
    q_entry.mag_x = axis_mag(point_x, ref_x);
    q_entry.mag_y = axis_mag(point_y, ref_y);
    q_entry.mag_z = axis_mag(point_z, ref_z);
    q_entry.last  = last_point;
  end

endmodule

// ===== src/mpd_queue.sv =====
// short fifo of point entries between front and back
module mpd_queue import mpd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head_entry,
  output logic   full,
  output logic   empty
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty      = (count == '0);
  assign head_entry = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

// ===== src/mpd_isqrt.sv =====
// integer square root, one result bit per cycle
module mpd_isqrt import mpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  root_req_t req,
  output root_rsp_t rsp
);

  localparam logic [ROOT_CNT_BITS-1:0] LAST_STEP = ROOT_CNT_BITS'(DIST_BITS - 1);

  logic                     busy;
  logic                     done;
  logic [ROOT_CNT_BITS-1:0] step;
  logic [SQ_BITS-1:0]       radicand;
  logic [DIST_BITS:0]       rem;
  logic [DIST_BITS-1:0]     root;

  logic [DIST_BITS+2:0] rem_sh;
  logic [DIST_BITS+2:0] trial;
  logic                 fits;
  logic [DIST_BITS+2:0] rem_sub;

  // one restoring step: bring down two bits, try root*4+1
  always_comb begin
    rem_sh  = {rem, radicand[SQ_BITS-1 -: 2]};
    trial   = {1'b0, root, 2'b01};
    fits    = (rem_sh >= trial);
    rem_sub = rem_sh - trial;
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + ROOT_CNT_BITS'(1);
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      radicand <= req.operand;
      rem      <= '0;
      root     <= '0;
    end else if (busy) begin
      radicand <= {radicand[SQ_BITS-3:0], 2'b00};
      rem      <= fits ? rem_sub[DIST_BITS:0] : rem_sh[DIST_BITS:0];
      root     <= {root[DIST_BITS-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

// ===== src/mpd_back.sv =====
// back end: squares, sums, keeps the cloud minimum and emits its root
module mpd_back import mpd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [DIST_BITS-1:0] start_distance,
  input  logic                 q_empty,
  input  entry_t               q_head,
  output logic                 q_pop,
  output root_req_t            root_req,
  input  root_rsp_t            root_rsp,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DIST_BITS-1:0] least_dist
);

  back_state_t          state;
  back_state_t          state_next;
  entry_t               work;
  axis_t                axis;
  logic [SQ_BITS-1:0]   prod;
  logic [SQ_BITS-1:0]   acc;
  logic [SQ_BITS-1:0]   best;
  logic [SQ_BITS-1:0]   root_op;
  logic [DIST_BITS-1:0] mul_op;
  logic [SQ_BITS-1:0]   new_best;

  // shared multiplier operand: an axis magnitude or the start distance
  always_comb begin
    if (state == BK_SEED_MUL) begin
      mul_op = start_distance;
    end else begin
      unique case (axis)
        AX_X:    mul_op = DIST_BITS'(work.mag_x);
        AX_Y:    mul_op = DIST_BITS'(work.mag_y);
        AX_Z:    mul_op = DIST_BITS'(work.mag_z);
        default: mul_op = '0;
      endcase
    end
  end

  assign new_best = (acc < best) ? acc : best;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake outputs
  always_comb begin
    state_next       = state;
    q_pop            = 1'b0;
    root_req.start   = 1'b0;
    root_req.operand = root_op;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = BK_MUL;
        end
      end
      BK_MUL: state_next = BK_ADD;
      BK_ADD: state_next = (axis == AX_Z) ? BK_CMP : BK_MUL;
      BK_CMP: state_next = work.last ? BK_SEED_MUL : BK_IDLE;
      BK_SEED_MUL: state_next = BK_SEED_WR;
      BK_SEED_WR: state_next = BK_ROOT_START;
      BK_ROOT_START: begin
        if (!out_valid) begin
          root_req.start = 1'b1;
          state_next     = BK_ROOT_WAIT;
        end
      end
      BK_ROOT_WAIT: begin
        if (root_rsp.done) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          work <= q_head;
          axis <= AX_X;
          acc  <= '0;
        end
      end
      BK_MUL, BK_SEED_MUL: prod <= SQ_BITS'(mul_op) * SQ_BITS'(mul_op);
      BK_ADD: begin
        acc <= acc + prod;
        unique case (axis)
          AX_X:    axis <= AX_Y;
          AX_Y:    axis <= AX_Z;
          default: axis <= AX_Z;
        endcase
      end
      BK_CMP: root_op <= new_best;
      default: ;
    endcase
  end

  // running minimum, reseeded after each cloud
  always_ff @(posedge clk) begin
    if (rst) begin
      best <= START_SQ_RESET;
    end else if (state == BK_CMP) begin
      best <= new_best;
    end else if (state == BK_SEED_WR) begin
      best <= prod;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == BK_ROOT_WAIT && root_rsp.done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_ROOT_WAIT && root_rsp.done) begin
      least_dist <= root_rsp.root;
    end
  end

endmodule

// ===== src/min_point_distance.sv =====
// least distance of each point cloud to a reference point, floor of the root
// back end per point: pop, square and add for x, y and z, then compare
// a last point then reseeds the minimum and starts the root when the output is free
// points go one at a time through the single shared 25x25 multiplier
// a 4-entry queue lets the input take beats while the back end or output stalls
// reset: references 0, start distance 100 m, minimum seeded with its square
module min_point_distance import mpd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COORD_BITS-1:0]   point_x,
  input  logic [COORD_BITS-1:0]   point_y,
  input  logic [COORD_BITS-1:0]   point_z,
  input  logic                    last_point,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [DIST_BITS-1:0]    least_dist,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [DIST_BITS-1:0]    cfg_data
);

  logic [COORD_BITS-1:0] ref_x;
  logic [COORD_BITS-1:0] ref_y;
  logic [COORD_BITS-1:0] ref_z;
  logic [DIST_BITS-1:0]  start_distance;

  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  entry_t    q_in;
  entry_t    q_head;
  root_req_t root_req;
  root_rsp_t root_rsp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_x          <= '0;
      ref_y          <= '0;
      ref_z          <= '0;
      start_distance <= START_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_e_t'(cfg_index))
        CFG_REF_X:      ref_x <= cfg_data[COORD_BITS-1:0];
        CFG_REF_Y:      ref_y <= cfg_data[COORD_BITS-1:0];
        CFG_REF_Z:      ref_z <= cfg_data[COORD_BITS-1:0];
        CFG_START_DIST: start_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  // point intake
  mpd_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .last_point (last_point),
    .ref_x      (ref_x),
    .ref_y      (ref_y),
    .ref_z      (ref_z),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_in)
  );

  // decoupling queue
  mpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head_entry (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // distance, minimum and output
  mpd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .start_distance (start_distance),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .root_req       (root_req),
    .root_rsp       (root_rsp),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .least_dist     (least_dist)
  );

  // square root unit
  mpd_isqrt u_isqrt (
    .clk (clk),
    .rst (rst),
    .req (root_req),
    .rsp (root_rsp)
  );

`ifndef SYNTHESIS
  // the back end never pops an empty queue
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // a root is only started when the output register is free
  a_root_start_free: assert property (@(posedge clk) disable iff (rst)
    root_req.start |-> !out_valid)
    else $error("root started with result pending");

  // a finished root always finds the output register free
  a_root_done_free: assert property (@(posedge clk) disable iff (rst)
    root_rsp.done |-> !out_valid)
    else $error("root finished with result pending");

  // a result beat appears only right after a root completes
  a_out_after_root: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(root_rsp.done))
    else $error("result beat without a root");
`endif

endmodule
